// ===== sv/egbp_pkg.sv =====
// ----------------------------------------------------------------------------
// egbp_pkg: shared types and constants of the exp-Golomb bit packer
// Item kinds, the op code handed from the front end to the packing
// back end, and the word geometry.
// ----------------------------------------------------------------------------
package egbp_pkg;

    localparam int WORD_BITS   = 32;
    localparam int WORD_BYTES  = WORD_BITS / 8;
    localparam int LEN_W       = 6;
    localparam int BYTE_CNT_W  = $clog2(WORD_BYTES + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] MAX_CODE  = 16'hFFFE;
    localparam logic [15:0] SE_ILLEGAL = 16'h8000;

    typedef enum logic [1:0] {
        KIND_RAW   = 2'd0,
        KIND_UE    = 2'd1,
        KIND_SE    = 2'd2,
        KIND_FLUSH = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_FLUSH  = 2'd1,
        OP_ERROR  = 2'd2
    } op_code_t;

    typedef struct packed {
        op_code_t               code;
        logic [WORD_BITS-1:0]   bits;
        logic [LEN_W-1:0]       len;
    } op_t;

endpackage

// ===== sv/egbp_in_if.sv =====
// ----------------------------------------------------------------------------
// egbp_in_if: input item channel
// Valid/ready channel carrying one packer command word.
// ----------------------------------------------------------------------------
interface egbp_in_if;

    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [31:0]        raw_value;
    logic [5:0]         bit_length;
    logic [15:0]        code_number;
    logic signed [15:0] signed_number;

    modport source
    (
        output valid, kind, raw_value, bit_length, code_number, signed_number,
        input  ready
    );

    modport sink
    (
        input  valid, kind, raw_value, bit_length, code_number, signed_number,
        output ready
    );

endinterface

// ===== sv/egbp_out_if.sv =====
// ----------------------------------------------------------------------------
// egbp_out_if: result channel
// Valid/ready channel carrying one bitstream byte or an error word.
// ----------------------------------------------------------------------------
interface egbp_out_if;

    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       range_error;
    logic       last;

    modport source
    (
        output valid, out_byte, byte_valid, range_error, last,
        input  ready
    );

    modport sink
    (
        input  valid, out_byte, byte_valid, range_error, last,
        output ready
    );

endinterface

// ===== sv/egbp_front.sv =====
// ----------------------------------------------------------------------------
// egbp_front: command classifier
// Turns each input word into an append, flush or error op: masks raw
// fields, maps signed values, and builds the exp-Golomb code and length.
// ----------------------------------------------------------------------------
module egbp_front
    import egbp_pkg::*;
(
    egbp_in_if.sink     in_ch,
    output op_t         op,
    output logic        push,
    input  logic        q_ready
);

    logic [LEN_W-1:0]     raw_len;
    logic [4:0]           mask_sh;
    logic [WORD_BITS-1:0] raw_mask;
    logic [15:0]          neg_mag;
    logic [15:0]          eg_val;
    logic [15:0]          eg_x;
    logic [3:0]           prefix;
    logic                 eg_err;
    logic                 drop;

    assign in_ch.ready = q_ready;

    always_comb
    begin
        raw_len  = (in_ch.bit_length > LEN_W'(WORD_BITS)) ? LEN_W'(WORD_BITS)
                                                          : in_ch.bit_length;
        mask_sh  = 5'(LEN_W'(WORD_BITS) - raw_len);
        raw_mask = {WORD_BITS{1'b1}} >> mask_sh;
        neg_mag  = 16'd0 - $unsigned(in_ch.signed_number);

        eg_val = 16'd0;
        eg_err = 1'b0;
        unique case (kind_t'(in_ch.kind))
            KIND_UE:
            begin
                eg_val = in_ch.code_number;
                eg_err = in_ch.code_number > MAX_CODE;
            end
            KIND_SE:
            begin
                if ($unsigned(in_ch.signed_number) == SE_ILLEGAL)
                begin
                    eg_err = 1'b1;
                end
                else if (in_ch.signed_number[15])
                begin
                    eg_val = {neg_mag[14:0], 1'b0};
                end
                else if (in_ch.signed_number != 16'sd0)
                begin
                    eg_val = {in_ch.signed_number[14:0], 1'b0} - 16'd1;
                end
            end
            default:
            begin
                eg_val = 16'd0;
            end
        endcase

        // leading one position gives the prefix length
        eg_x   = eg_val + 16'd1;
        prefix = 4'd0;
        for (int i = 1; i < 16; i++)
        begin
            if (eg_x[i])
            begin
                prefix = 4'(i);
            end
        end

        op   = '{code: OP_APPEND, bits: '0, len: '0};
        drop = 1'b0;
        unique case (kind_t'(in_ch.kind))
            KIND_RAW:
            begin
                op.bits = in_ch.raw_value & raw_mask;
                op.len  = raw_len;
                drop    = raw_len == '0;
            end
            KIND_UE, KIND_SE:
            begin
                op.code = eg_err ? OP_ERROR : OP_APPEND;
                op.bits = {{(WORD_BITS-16){1'b0}}, eg_x};
                op.len  = {1'b0, prefix, 1'b1};
            end
            KIND_FLUSH:
            begin
                op.code = OP_FLUSH;
            end
            default:
            begin
                op.code = OP_FLUSH;
            end
        endcase

        push = in_ch.valid && q_ready && !drop;
    end

endmodule

// ===== sv/egbp_queue.sv =====
// ----------------------------------------------------------------------------
// egbp_queue: op queue
// Short FIFO between the classifier and the packer so each side can
// stall on its own.
// ----------------------------------------------------------------------------
module egbp_queue
    import egbp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  op_t     wr_op,
    input  logic    wr_en,
    output logic    wr_ready,
    output op_t     rd_op,
    output logic    rd_valid,
    input  logic    rd_en
);

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    op_t              slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   cnt_reg, cnt_next;

    assign wr_ready = cnt_reg != (PTR_W+1)'(QUEUE_DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign rd_op    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (!wr_en && rd_en)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slots_reg[wr_ptr_reg] <= wr_op;
        end
    end

endmodule

// ===== sv/egbp_back.sv =====
// ----------------------------------------------------------------------------
// egbp_back: bit accumulator and byte emitter
// Packs appended fields MSB-first into the word, hands full or flushed
// words to a byte shifter that drives the result channel.
// ----------------------------------------------------------------------------
module egbp_back
    import egbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  op_t         op,
    input  logic        op_valid,
    output logic        pop,
    egbp_out_if.source  out_ch
);

    logic [WORD_BITS-1:0]  acc_reg, acc_next;
    logic [LEN_W-1:0]      free_reg, free_next;
    logic [WORD_BITS-1:0]  word_reg, word_next;
    logic [BYTE_CNT_W-1:0] cnt_reg, cnt_next;
    logic                  err_reg, err_next;

    logic                  fits;
    logic [LEN_W-1:0]      rem;
    logic [4:0]            put_sh;
    logic [LEN_W-1:0]      used;
    logic [LEN_W-1:0]      used_rnd;
    logic [BYTE_CNT_W-1:0] flush_bytes;
    logic                  emits;
    logic                  out_take;
    logic                  load_ok;

    assign out_ch.valid       = cnt_reg != '0;
    assign out_ch.out_byte    = word_reg[WORD_BITS-1 -: 8];
    assign out_ch.byte_valid  = !err_reg;
    assign out_ch.range_error = err_reg;
    assign out_ch.last        = cnt_reg == BYTE_CNT_W'(1);

    always_comb
    begin
        fits        = op.len < free_reg;
        rem         = op.len - free_reg;
        put_sh      = 5'(free_reg - op.len);
        used        = LEN_W'(WORD_BITS) - free_reg;
        used_rnd    = used + LEN_W'(7);
        flush_bytes = BYTE_CNT_W'(used_rnd >> 3);

        unique case (op.code)
            OP_APPEND: emits = !fits;
            OP_FLUSH:  emits = flush_bytes != '0;
            OP_ERROR:  emits = 1'b1;
            default:   emits = 1'b0;
        endcase

        out_take = out_ch.valid && out_ch.ready;
        // shifter is free now or frees up on this edge
        load_ok  = (cnt_reg == '0) || (cnt_reg == BYTE_CNT_W'(1) && out_ch.ready);
        pop      = op_valid && (!emits || load_ok);

        acc_next  = acc_reg;
        free_next = free_reg;
        word_next = word_reg;
        cnt_next  = cnt_reg;
        err_next  = err_reg;

        if (out_take)
        begin
            word_next = word_reg << 8;
            cnt_next  = cnt_reg - 1'b1;
        end

        if (pop)
        begin
            unique case (op.code)
                OP_APPEND:
                begin
                    if (fits)
                    begin
                        acc_next  = acc_reg | (op.bits << put_sh);
                        free_next = free_reg - op.len;
                    end
                    else
                    begin
                        word_next = acc_reg | (op.bits >> rem[4:0]);
                        cnt_next  = BYTE_CNT_W'(WORD_BYTES);
                        err_next  = 1'b0;
                        acc_next  = (rem != '0) ? (op.bits << 5'(5'd0 - rem[4:0])) : '0;
                        free_next = LEN_W'(WORD_BITS) - rem;
                    end
                end
                OP_FLUSH:
                begin
                    if (emits)
                    begin
                        word_next = acc_reg;
                        cnt_next  = flush_bytes;
                        err_next  = 1'b0;
                    end
                    acc_next  = '0;
                    free_next = LEN_W'(WORD_BITS);
                end
                OP_ERROR:
                begin
                    word_next = '0;
                    cnt_next  = BYTE_CNT_W'(1);
                    err_next  = 1'b1;
                end
                default:
                begin
                    acc_next = acc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            free_reg <= LEN_W'(WORD_BITS);
            cnt_reg  <= '0;
            err_reg  <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            free_reg <= free_next;
            cnt_reg  <= cnt_next;
            err_reg  <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ===== sv/exp_golomb_bit_packer_unit.sv =====
// ----------------------------------------------------------------------------
// exp_golomb_bit_packer_unit: exp-Golomb bitstream packer
//
//   channel   dir   payload                                            kind
//   in_ch     in    kind, raw_value, bit_length, code_number,          valid/ready
//                   signed_number
//   out_ch    out   out_byte, byte_valid, range_error, last            valid/ready
//
// An item enters the op queue in the cycle it is accepted; a non-emitting
// item leaves it as soon as it reaches the head. A word that fills or a
// flush with bits pending goes out a byte at a time (up to 4) through the
// output byte shifter. The next word loads as the last byte leaves.
// Reset clears the accumulator, the queue and the shifter at once.
// Output stalls back up into the queue, then into in_ch.ready.
// ----------------------------------------------------------------------------
module exp_golomb_bit_packer_unit
    import egbp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    egbp_in_if.sink     in_ch,
    egbp_out_if.source  out_ch
);

    op_t  front_op;
    logic front_push;
    logic q_ready;
    op_t  back_op;
    logic back_valid;
    logic back_pop;

    egbp_front u_front
    (
        .in_ch   (in_ch),
        .op      (front_op),
        .push    (front_push),
        .q_ready (q_ready)
    );

    egbp_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_op    (front_op),
        .wr_en    (front_push),
        .wr_ready (q_ready),
        .rd_op    (back_op),
        .rd_valid (back_valid),
        .rd_en    (back_pop)
    );

    egbp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (back_op),
        .op_valid (back_valid),
        .pop      (back_pop),
        .out_ch   (out_ch)
    );

endmodule

// ===== sv/egbp_checker.sv =====
// ----------------------------------------------------------------------------
// egbp_checker: result channel checks
// Watches the top level result port for malformed or unstable results.
// ----------------------------------------------------------------------------
module egbp_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       byte_valid,
    input logic       range_error,
    input logic       last
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte)
            && $stable(byte_valid) && $stable(range_error) && $stable(last))
        else $error("stalled result changed");

    a_byte_or_error: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> byte_valid != range_error)
        else $error("result is neither a byte nor an error");

    a_error_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && range_error |-> last && out_byte == 8'd0)
        else $error("error result not a lone zero result");

    a_only_bytes_continue: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> byte_valid)
        else $error("non-final result carries no byte");

endmodule

bind exp_golomb_bit_packer_unit egbp_checker u_egbp_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_byte    (out_ch.out_byte),
    .byte_valid  (out_ch.byte_valid),
    .range_error (out_ch.range_error),
    .last        (out_ch.last)
);
